[design/magic_byte_file_type_sniffer_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the magic byte sniffer
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAGIC_BYTE_FILE_TYPE_SNIFFER_CORE_MACROS_SVH
`define MAGIC_BYTE_FILE_TYPE_SNIFFER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define MBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MBS_ASSERT_SAME(label, ante, cons, msg)
`define MBS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[design/mbs_pkg.sv]
// ----------------------------------------------------------------------------
// mbs_pkg
// Types, file kind codes and signature constants for the magic byte sniffer.
// ----------------------------------------------------------------------------
package mbs_pkg;

    localparam int LEAD_N = 14;
    localparam int WIN_N  = 20;

    // Input request: one header byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    // Result: file kind and bytes examined
    typedef struct packed {
        logic [4:0] file_kind;
        logic [9:0] bytes_used;
    } result_t;

    // Per-cell control of the window row
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Byte count thresholds used by the classifier
    typedef struct packed {
        logic ge2;
        logic ge3;
        logic ge4;
        logic ge5;
        logic ge6;
        logic ge8;
        logic ge12;
        logic ge14;
        logic ge189;
        logic ge193;
        logic ge377;
        logic ge385;
    } count_ge_t;

    // Snapshot handed to the classifier
    typedef struct packed {
        logic [LEAD_N*8-1:0] lead_flat;      // byte 0 in the top bits
        logic [5:0]          pattern_flags;
        logic [3:0]          sync_flags;
        count_ge_t           ge;
    } sniff_state_t;

    // File kind codes
    localparam logic [4:0] KIND_NONE     = 5'd0;
    localparam logic [4:0] KIND_PDF      = 5'd1;
    localparam logic [4:0] KIND_WEBM     = 5'd2;
    localparam logic [4:0] KIND_MKV      = 5'd3;
    localparam logic [4:0] KIND_M4V      = 5'd4;
    localparam logic [4:0] KIND_M4A      = 5'd5;
    localparam logic [4:0] KIND_M4B      = 5'd6;
    localparam logic [4:0] KIND_MOV      = 5'd7;
    localparam logic [4:0] KIND_MP4      = 5'd8;
    localparam logic [4:0] KIND_AVI      = 5'd9;
    localparam logic [4:0] KIND_WAV      = 5'd10;
    localparam logic [4:0] KIND_WEBP     = 5'd11;
    localparam logic [4:0] KIND_PNG      = 5'd12;
    localparam logic [4:0] KIND_GIF      = 5'd13;
    localparam logic [4:0] KIND_JPG      = 5'd14;
    localparam logic [4:0] KIND_BMP      = 5'd15;
    localparam logic [4:0] KIND_TS       = 5'd16;
    localparam logic [4:0] KIND_WMV      = 5'd17;
    localparam logic [4:0] KIND_WMA      = 5'd18;
    localparam logic [4:0] KIND_FLAC     = 5'd19;
    localparam logic [4:0] KIND_MP3      = 5'd20;
    localparam logic [4:0] KIND_OGG      = 5'd21;
    localparam logic [4:0] KIND_EPUB     = 5'd22;
    localparam logic [4:0] KIND_ZIP      = 5'd23;
    localparam logic [4:0] KIND_MOBI     = 5'd24;
    localparam logic [4:0] KIND_RAR      = 5'd25;
    localparam logic [4:0] KIND_7Z       = 5'd26;
    localparam logic [4:0] KIND_GZ       = 5'd27;
    localparam logic [4:0] KIND_BZ2      = 5'd28;
    localparam logic [4:0] KIND_XZ       = 5'd29;
    localparam logic [4:0] KIND_TAR      = 5'd30;
    localparam logic [4:0] KIND_COMPRESS = 5'd31;

    // Pattern flag bits
    localparam int PF_WEBM  = 0;
    localparam int PF_EPUB  = 1;
    localparam int PF_ASFV  = 2;
    localparam int PF_ASFA  = 3;
    localparam int PF_MOBI  = 4;
    localparam int PF_USTAR = 5;

    // Sliding window substrings
    localparam logic [31:0]  PAT_WEBM  = "webm";
    localparam logic [159:0] PAT_EPUB  = "application/epub+zip";
    localparam logic [127:0] PAT_ASFV  = 128'hC0EF19BC_4D5BCF11_A8FD0080_5F5C442B;
    localparam logic [127:0] PAT_ASFA  = 128'h409E69F8_4D5BCF11_A8FD0080_5F5C442B;
    localparam logic [63:0]  PAT_MOBI  = "BOOKMOBI";
    localparam logic [39:0]  PAT_USTAR = "ustar";

    // Fixed-offset signature positions (byte index before increment)
    localparam int POS_MOBI_END  = 67;
    localparam int POS_USTAR_END = 261;
    localparam int POS_SYNC0     = 188;
    localparam int POS_SYNC1     = 192;
    localparam int POS_SYNC2     = 376;
    localparam int POS_SYNC3     = 384;
    localparam logic [7:0] SYNC_BYTE = 8'h47;

    // Leading byte signatures
    localparam logic [39:0] SIG_PDF   = "%PDF-";
    localparam logic [31:0] SIG_EBML  = 32'h1A45DFA3;
    localparam logic [31:0] SIG_FTYP  = "ftyp";
    localparam logic [31:0] SIG_MOOV  = "moov";
    localparam logic [31:0] SIG_M4V   = "M4V ";
    localparam logic [31:0] SIG_M4A   = "M4A ";
    localparam logic [31:0] SIG_M4B   = "M4B ";
    localparam logic [31:0] SIG_QT    = "qt  ";
    localparam logic [31:0] SIG_RIFF  = "RIFF";
    localparam logic [31:0] SIG_AVI   = "AVI ";
    localparam logic [31:0] SIG_WAVE  = "WAVE";
    localparam logic [31:0] SIG_WEBP  = "WEBP";
    localparam logic [63:0] SIG_PNG   = 64'h89504E47_0D0A1A0A;
    localparam logic [47:0] SIG_GIF87 = "GIF87a";
    localparam logic [47:0] SIG_GIF89 = "GIF89a";
    localparam logic [23:0] SIG_JPG   = 24'hFFD8FF;
    localparam logic [15:0] SIG_BMP   = "BM";
    localparam logic [63:0] SIG_ASF   = 64'h3026B275_8E66CF11;
    localparam logic [31:0] SIG_FLAC  = "fLaC";
    localparam logic [23:0] SIG_ID3   = "ID3";
    localparam logic [7:0]  SIG_MP3_0 = 8'hFF;
    localparam logic [7:0]  MP3_MASK  = 8'hE6;
    localparam logic [7:0]  MP3_SYNC  = 8'hE2;
    localparam logic [31:0] SIG_OGG   = "OggS";
    localparam logic [31:0] SIG_ZIP   = 32'h504B0304;
    localparam logic [47:0] SIG_RAR   = 48'h52617221_1A07;
    localparam logic [47:0] SIG_7Z    = 48'h377ABCAF_271C;
    localparam logic [23:0] SIG_GZ    = 24'h1F8B08;
    localparam logic [23:0] SIG_BZ2   = "BZh";
    localparam logic [47:0] SIG_XZ    = 48'hFD377A58_5A00;
    localparam logic [15:0] SIG_LZW   = 16'h1F9D;

endpackage

[design/mbs_win_cell.sv]
// ----------------------------------------------------------------------------
// mbs_win_cell
// One byte of the sliding search window. Takes its neighbor's byte on a
// shift, clears at the end of a file, and shows its post-shift value.
// ----------------------------------------------------------------------------
module mbs_win_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mbs_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         din,
    output logic [7:0]         q,
    output logic [7:0]         look
);
    import mbs_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Post-shift value, seen by the matchers this cycle
    assign look = ctrl.shift ? din : byte_reg;

    // Clear wins over shift
    assign byte_next = ctrl.clear ? 8'h00 : look;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

[design/mbs_classify.sv]
// ----------------------------------------------------------------------------
// mbs_classify
// Priority classifier: maps the leading bytes, counts and flags of one
// file to a single file kind code.
// ----------------------------------------------------------------------------
module mbs_classify (
    input  mbs_pkg::sniff_state_t st,
    output logic [4:0]            file_kind
);
    import mbs_pkg::*;

    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [15:0] s0_2;
    logic [23:0] s0_3;
    logic [31:0] s0_4;
    logic [39:0] s0_5;
    logic [47:0] s0_6;
    logic [63:0] s0_8;
    logic [31:0] s4_4;
    logic [31:0] s6_4;
    logic [31:0] s8_4;
    logic        riff;
    logic        ftyp;
    logic        ts_hit;

    // Slices of the leading bytes, byte 0 on top
    assign h0   = st.lead_flat[111 -: 8];
    assign h1   = st.lead_flat[103 -: 8];
    assign s0_2 = st.lead_flat[111 -: 16];
    assign s0_3 = st.lead_flat[111 -: 24];
    assign s0_4 = st.lead_flat[111 -: 32];
    assign s0_5 = st.lead_flat[111 -: 40];
    assign s0_6 = st.lead_flat[111 -: 48];
    assign s0_8 = st.lead_flat[111 -: 64];
    assign s4_4 = st.lead_flat[79 -: 32];
    assign s6_4 = st.lead_flat[63 -: 32];
    assign s8_4 = st.lead_flat[47 -: 32];

    assign riff = st.ge.ge12 && (s0_4 == SIG_RIFF);
    assign ftyp = st.ge.ge8 && (s4_4 == SIG_FTYP);

    // Transport stream: sync byte repeated at packet pitch 188 or 192
    assign ts_hit = st.ge.ge189 && (h0 == SYNC_BYTE) &&
                    ((st.sync_flags[0] && (!st.ge.ge377 || st.sync_flags[2])) ||
                     (st.ge.ge193 && st.sync_flags[1] &&
                      (!st.ge.ge385 || st.sync_flags[3])));

    // Priority chain
    always_comb
    begin
        file_kind = KIND_NONE;
        if (st.ge.ge5 && s0_5 == SIG_PDF)
            file_kind = KIND_PDF;
        else if (st.ge.ge4 && s0_4 == SIG_EBML)
            file_kind = st.pattern_flags[PF_WEBM] ? KIND_WEBM : KIND_MKV;
        else if (ftyp)
        begin
            if (st.ge.ge12 && s8_4 == SIG_M4V)
                file_kind = KIND_M4V;
            else if (st.ge.ge12 && s8_4 == SIG_M4A)
                file_kind = KIND_M4A;
            else if (st.ge.ge12 && s8_4 == SIG_M4B)
                file_kind = KIND_M4B;
            else if (st.ge.ge12 && s8_4 == SIG_QT)
                file_kind = KIND_MOV;
            else
                file_kind = KIND_MP4;
        end
        else if (st.ge.ge8 && s4_4 == SIG_MOOV)
            file_kind = KIND_MP4;
        else if (riff && s8_4 == SIG_AVI)
            file_kind = KIND_AVI;
        else if (riff && s8_4 == SIG_WAVE)
            file_kind = KIND_WAV;
        else if (riff && s8_4 == SIG_WEBP)
            file_kind = KIND_WEBP;
        else if (st.ge.ge8 && s0_8 == SIG_PNG)
            file_kind = KIND_PNG;
        else if (st.ge.ge6 && (s0_6 == SIG_GIF87 || s0_6 == SIG_GIF89))
            file_kind = KIND_GIF;
        else if (st.ge.ge3 && s0_3 == SIG_JPG)
            file_kind = KIND_JPG;
        else if (st.ge.ge14 && s0_2 == SIG_BMP && s6_4 == 32'h0)
            file_kind = KIND_BMP;
        else if (ts_hit)
            file_kind = KIND_TS;
        else if (st.ge.ge8 && s0_8 == SIG_ASF)
            file_kind = (!st.pattern_flags[PF_ASFV] && st.pattern_flags[PF_ASFA]) ?
                        KIND_WMA : KIND_WMV;
        else if (st.ge.ge4 && s0_4 == SIG_FLAC)
            file_kind = KIND_FLAC;
        else if (st.ge.ge3 && s0_3 == SIG_ID3)
            file_kind = KIND_MP3;
        else if (st.ge.ge2 && h0 == SIG_MP3_0 && (h1 & MP3_MASK) == MP3_SYNC)
            file_kind = KIND_MP3;
        else if (st.ge.ge4 && s0_4 == SIG_OGG)
            file_kind = KIND_OGG;
        else if (st.ge.ge4 && s0_4 == SIG_ZIP)
            file_kind = st.pattern_flags[PF_EPUB] ? KIND_EPUB : KIND_ZIP;
        else if (st.pattern_flags[PF_MOBI])
            file_kind = KIND_MOBI;
        else if (st.ge.ge6 && s0_6 == SIG_RAR)
            file_kind = KIND_RAR;
        else if (st.ge.ge6 && s0_6 == SIG_7Z)
            file_kind = KIND_7Z;
        else if (st.ge.ge3 && s0_3 == SIG_GZ)
            file_kind = KIND_GZ;
        else if (st.ge.ge3 && s0_3 == SIG_BZ2)
            file_kind = KIND_BZ2;
        else if (st.ge.ge6 && s0_6 == SIG_XZ)
            file_kind = KIND_XZ;
        else if (st.pattern_flags[PF_USTAR])
            file_kind = KIND_TAR;
        else if (st.ge.ge2 && s0_2 == SIG_LZW)
            file_kind = KIND_COMPRESS;
    end

endmodule

[design/magic_byte_file_type_sniffer_core.sv]
// The result is in the output register in the cycle after the request
// carrying last_byte is accepted. Throughput: one header byte per cycle
// unless a last byte waits for room for its result; the 20-cell window
// row shifts on each byte below MAX_HEADER and all matchers compare it
// in parallel. Reset: rst_n (async, active low) clears the count, flags,
// window and output valid; the block is ready right after reset.
// ----------------------------------------------------------------------------
// magic_byte_file_type_sniffer_core
// Streams file header bytes, tracks signatures and emits one file kind code
// per file on the byte marked last.
// ----------------------------------------------------------------------------
`include "magic_byte_file_type_sniffer_core_macros.svh"

module magic_byte_file_type_sniffer_core #(
    parameter int MAX_HEADER = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  mbs_pkg::byte_req_t byte_req,
    output logic               result_valid,
    input  logic               result_ready,
    output mbs_pkg::result_t   result
);
    import mbs_pkg::*;

    localparam int CW_RAW = $clog2(MAX_HEADER + 1);
    localparam int CW     = (CW_RAW < 10) ? 10 : CW_RAW;

    logic                accept;
    logic                advance;
    logic                done;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_upd;
    logic [CW-1:0]       count_next;
    logic [5:0]          pattern_flags_reg;
    logic [5:0]          pattern_flags_upd;
    logic [5:0]          pattern_flags_next;
    logic [5:0]          pattern_hits;
    logic [3:0]          sync_flags_reg;
    logic [3:0]          sync_flags_upd;
    logic [3:0]          sync_flags_next;
    logic [3:0]          sync_hits;
    logic [7:0]          lead_reg [LEAD_N];
    logic [7:0]          lead_next [LEAD_N];
    logic [LEAD_N*8-1:0] lead_flat;
    logic [7:0]          win_q [WIN_N];
    logic [7:0]          win_look [WIN_N];
    logic [WIN_N*8-1:0]  win_flat;
    cell_ctrl_t          cell_ctrl;
    count_ge_t           ge;
    sniff_state_t        snap;
    logic [4:0]          kind;
    logic                result_valid_reg;
    logic                result_valid_next;
    result_t             result_reg;
    result_t             result_next;

    // Handshake: only a last byte needs room in the output register
    assign byte_ready = result_ready || !result_valid_reg || !byte_req.last_byte;
    assign accept     = byte_valid && byte_ready;
    assign advance    = accept && (count_reg < CW'(MAX_HEADER));
    assign done       = accept && byte_req.last_byte;

    // Window row: newest byte enters at the last cell
    assign cell_ctrl.shift = advance;
    assign cell_ctrl.clear = done;

    for (genvar i = 0; i < WIN_N; i++)
    begin : g_win
        logic [7:0] din;
        if (i == WIN_N - 1)
        begin : g_head
            assign din = byte_req.data_byte;
        end
        else
        begin : g_body
            assign din = win_q[i + 1];
        end
        mbs_win_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .din   (din),
            .q     (win_q[i]),
            .look  (win_look[i])
        );
        assign win_flat[(WIN_N - 1 - i)*8 +: 8] = win_look[i];
    end

    // Byte count
    assign count_upd  = advance ? count_reg + 1'b1 : count_reg;
    assign count_next = done ? '0 : count_upd;

    // Substring matches on the shifted window
    always_comb
    begin
        pattern_hits = '0;
        pattern_hits[PF_WEBM]  = (count_upd >= CW'(4))  && (win_flat[31:0]  == PAT_WEBM);
        pattern_hits[PF_EPUB]  = (count_upd >= CW'(20)) && (win_flat[159:0] == PAT_EPUB);
        pattern_hits[PF_ASFV]  = (count_upd >= CW'(16)) && (win_flat[127:0] == PAT_ASFV);
        pattern_hits[PF_ASFA]  = (count_upd >= CW'(16)) && (win_flat[127:0] == PAT_ASFA);
        pattern_hits[PF_MOBI]  = (count_reg == CW'(POS_MOBI_END)) &&
                                 (win_flat[63:0] == PAT_MOBI);
        pattern_hits[PF_USTAR] = (count_reg == CW'(POS_USTAR_END)) &&
                                 (win_flat[39:0] == PAT_USTAR);
    end

    assign pattern_flags_upd  = pattern_flags_reg | (advance ? pattern_hits : 6'b0);
    assign pattern_flags_next = done ? '0 : pattern_flags_upd;

    // Sync bytes at fixed offsets
    always_comb
    begin
        sync_hits    = '0;
        sync_hits[0] = (count_reg == CW'(POS_SYNC0));
        sync_hits[1] = (count_reg == CW'(POS_SYNC1));
        sync_hits[2] = (count_reg == CW'(POS_SYNC2));
        sync_hits[3] = (count_reg == CW'(POS_SYNC3));
    end

    assign sync_flags_upd  = sync_flags_reg |
                             ((advance && byte_req.data_byte == SYNC_BYTE) ? sync_hits : 4'b0);
    assign sync_flags_next = done ? '0 : sync_flags_upd;

    // Leading bytes, written at their position
    for (genvar i = 0; i < LEAD_N; i++)
    begin : g_lead
        assign lead_next[i] = (advance && count_reg == CW'(i)) ? byte_req.data_byte
                                                                 : lead_reg[i];
        assign lead_flat[(LEAD_N - 1 - i)*8 +: 8] = lead_next[i];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LEAD_N; i++)
        begin
            lead_reg[i] <= lead_next[i];
        end
    end

    // Count thresholds for the classifier
    always_comb
    begin
        ge.ge2   = count_upd >= CW'(2);
        ge.ge3   = count_upd >= CW'(3);
        ge.ge4   = count_upd >= CW'(4);
        ge.ge5   = count_upd >= CW'(5);
        ge.ge6   = count_upd >= CW'(6);
        ge.ge8   = count_upd >= CW'(8);
        ge.ge12  = count_upd >= CW'(12);
        ge.ge14  = count_upd >= CW'(14);
        ge.ge189 = count_upd >= CW'(189);
        ge.ge193 = count_upd >= CW'(193);
        ge.ge377 = count_upd >= CW'(377);
        ge.ge385 = count_upd >= CW'(385);
    end

    assign snap.lead_flat     = lead_flat;
    assign snap.pattern_flags = pattern_flags_upd;
    assign snap.sync_flags    = sync_flags_upd;
    assign snap.ge            = ge;

    mbs_classify u_classify (
        .st        (snap),
        .file_kind (kind)
    );

    // Output register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (done)
        begin
            result_valid_next      = 1'b1;
            result_next.file_kind  = kind;
            result_next.bytes_used = count_upd[9:0];
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            pattern_flags_reg <= '0;
            sync_flags_reg    <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg         <= count_next;
            pattern_flags_reg <= pattern_flags_next;
            sync_flags_reg    <= sync_flags_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `MBS_ASSERT_NEXT(a_last_gives_result, done, result_valid_reg, "no result after last byte")
    `MBS_ASSERT_NEXT(a_last_clears_count, done, count_reg == '0, "count not cleared")
    `MBS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(MAX_HEADER), "count over limit")
    `MBS_ASSERT_SAME(a_flags_need_bytes, count_reg == '0, (pattern_flags_reg == '0) && (sync_flags_reg == '0), "flags set with no bytes")

endmodule
